FILE: rtl/ara_pkg.sv
package ara_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PTR_W = IDX_W + 1;
    localparam int ADDR_W = 38;
    localparam int PAGE_BITS = 12;
    localparam logic [PTR_W-1:0] PTR_NONE = {PTR_W{1'b1}};
    localparam logic [ADDR_W-1:0] TOP_RESET = 38'd274877898752;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_PERM = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NOREGION = 3'd3;
    localparam logic [2:0] ST_UNSUP = 3'd4;

    typedef struct packed {
        logic                  opcode;
        logic [ADDR_W-1:0]     address;
        logic [ADDR_W-1:0]     length;
        logic                  want_read;
        logic                  want_write;
        logic                  is_shared;
        logic [3:0]            file_number;
        logic                  file_can_read;
        logic                  file_can_write;
        logic [ADDR_W-1:0]     start_offset;
    } t_req;

    typedef struct packed {
        logic [2:0]            status;
        logic [ADDR_W-1:0]     mapped_start;
        logic [3:0]            slot;
        logic                  removed_whole;
        logic                  needs_writeback;
        logic [3:0]            region_file;
        logic [ADDR_W-1:0]     region_offset;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture request
        logic scan;      // examine slot r_idx, advance
        logic walk;      // examine list node r_cur, advance
        logic commit;    // apply result
        logic clr_idx;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_unmap;
        logic early_done; // permission or alignment failure known
        logic scan_last;
        logic scan_hit;
        logic need_walk;
        logic walk_done;
    } t_sts;

    function automatic logic [ADDR_W-1:0] page_down(input logic [ADDR_W-1:0] v);
        return {v[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
    endfunction
endpackage

FILE: rtl/ara_if.sv
interface ara_req_if;
    import ara_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ara_rsp_if;
    import ara_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ara_ctrl.sv
module ara_ctrl
    import ara_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_WALK = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.early_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_sts.scan_hit || i_sts.scan_last) begin
                        n_state = S_DONE;
                        if (!i_sts.is_unmap && i_sts.scan_hit && i_sts.need_walk) begin
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: rtl/ara_dp.sv
module ara_dp
    import ara_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_data,
    output t_sts              o_sts,
    output t_rsp              o_rsp
);
    logic [ENTRIES-1:0] r_used;
    logic [ADDR_W-1:0]  r_start [ENTRIES];
    logic [ADDR_W-1:0]  r_end [ENTRIES];
    logic [PTR_W-1:0]   r_next [ENTRIES];
    logic [PTR_W-1:0]   r_prev [ENTRIES];
    logic [2:0]         r_rights [ENTRIES];
    logic [3:0]         r_file [ENTRIES];
    logic [ADDR_W-1:0]  r_offset [ENTRIES];
    logic [PTR_W-1:0]   r_head, r_tail;
    logic [ADDR_W-1:0]  r_top;

    t_req               r_req;
    logic [IDX_W-1:0]   r_idx;      // scan counter
    logic               r_found;
    logic [IDX_W-1:0]   r_slot;
    logic [PTR_W-1:0]   r_cur;
    logic [IDX_W:0]     r_steps;
    logic               r_placed;
    logic [PTR_W-1:0]   r_after;    // node that the new one follows
    t_rsp               r_rsp;

    logic [IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]  top_pg, len;
    logic [ADDR_W:0]    stop;
    logic               perm_bad, align_bad, hit, empty_list;
    logic [IDX_W-1:0]   cur_i, nx_i;
    logic [PTR_W-1:0]   nx;
    logic               fits;

    assign idx = r_idx;
    assign len = r_req.length;
    assign top_pg = page_down(r_top);
    assign stop = {1'b0, r_req.address} + {1'b0, len};
    assign perm_bad = (r_req.want_write && !r_req.file_can_write && r_req.is_shared)
                   || (r_req.want_read && !r_req.file_can_read);
    assign align_bad = (r_req.address[PAGE_BITS-1:0] != '0) || (stop[PAGE_BITS-1:0] != '0);
    assign empty_list = r_head[PTR_W-1] || r_tail[PTR_W-1];

    always_comb begin
        if (r_req.opcode) begin
            hit = r_used[idx] && (r_start[idx] <= r_req.address)
               && (stop <= {1'b0, r_end[idx]});
        end else begin
            hit = !r_used[idx];
        end
    end

    assign cur_i = r_cur[IDX_W-1:0];
    assign nx = r_next[cur_i];
    assign nx_i = nx[IDX_W-1:0];
    assign fits = !nx[PTR_W-1] && (r_end[nx_i] <= page_down(r_start[cur_i] - len));

    assign o_sts.is_unmap = r_req.opcode;
    assign o_sts.early_done = r_req.opcode ? align_bad : perm_bad;
    assign o_sts.scan_last = (idx == IDX_W'(ENTRIES - 1));
    assign o_sts.scan_hit = hit;
    assign o_sts.need_walk = !empty_list
                          && !(r_end[r_head[IDX_W-1:0]] <= page_down(top_pg - len));
    assign o_sts.walk_done = fits || nx[PTR_W-1]
                          || (r_steps == (IDX_W+1)'(ENTRIES - 1));
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TOP_RESET;
        end else if (i_cfg_we) begin
            r_top <= i_cfg_data;
        end
    end

    // Search bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
            r_found <= 1'b0;
            r_placed <= 1'b0;
        end else if (i_cmd.scan) begin
            if (hit) begin
                r_found <= 1'b1;
                r_slot <= idx;
                r_cur <= r_head;
                r_steps <= '0;
            end
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.walk) begin
            if (fits) begin
                r_placed <= 1'b1;
                r_after <= r_cur;
            end
            r_cur <= nx;
            r_steps <= r_steps + 1'b1;
        end
    end

    // Table update and response.
    always_ff @(posedge i_clk) begin
        logic [ADDR_W-1:0] e_end;
        logic [PTR_W-1:0]  pv, nn;
        logic [IDX_W-1:0]  s;
        t_rsp              rsp;
        s = r_slot;
        pv = r_prev[s];
        nn = r_next[s];
        e_end = top_pg;
        rsp = '0;
        if (!i_rst_n) begin
            r_used <= '0;
            r_head <= PTR_NONE;
            r_tail <= PTR_NONE;
        end else if (i_cmd.commit) begin
            if (!r_req.opcode) begin
                if (perm_bad) begin
                    rsp.status = ST_PERM;
                end else if (!r_found) begin
                    rsp.status = ST_FULL;
                end else begin
                    if (empty_list) begin
                        r_next[s] <= PTR_NONE;
                        r_prev[s] <= PTR_NONE;
                        r_head <= {1'b0, s};
                        r_tail <= {1'b0, s};
                    end else if (!o_sts.need_walk) begin
                        r_next[s] <= r_head;
                        r_prev[s] <= PTR_NONE;
                        r_prev[r_head[IDX_W-1:0]] <= {1'b0, s};
                        r_head <= {1'b0, s};
                    end else if (r_placed) begin
                        r_prev[s] <= r_after;
                        r_next[s] <= r_next[r_after[IDX_W-1:0]];
                        r_next[r_after[IDX_W-1:0]] <= {1'b0, s};
                        r_prev[r_next[r_after[IDX_W-1:0]][IDX_W-1:0]] <= {1'b0, s};
                        e_end = r_start[r_after[IDX_W-1:0]];
                    end else begin
                        r_next[s] <= PTR_NONE;
                        r_prev[s] <= r_tail;
                        r_next[r_tail[IDX_W-1:0]] <= {1'b0, s};
                        r_tail <= {1'b0, s};
                        e_end = r_start[r_tail[IDX_W-1:0]];
                    end
                    r_used[s] <= 1'b1;
                    r_end[s] <= e_end;
                    r_start[s] <= page_down(e_end - len);
                    r_rights[s] <= {r_req.is_shared, r_req.want_write, r_req.want_read};
                    r_file[s] <= r_req.file_number;
                    r_offset[s] <= r_req.start_offset;
                    rsp.status = ST_OK;
                    rsp.mapped_start = page_down(e_end - len);
                    rsp.slot = 4'(s);
                end
            end else if (align_bad) begin
                rsp.status = ST_UNSUP;
            end else if (!r_found) begin
                rsp.status = ST_NOREGION;
            end else begin
                rsp.slot = 4'(s);
                rsp.region_file = r_file[s];
                rsp.region_offset = r_offset[s];
                if (r_req.address > r_start[s] && stop < {1'b0, r_end[s]}) begin
                    rsp.status = ST_UNSUP;
                end else begin
                    rsp.status = ST_OK;
                    rsp.needs_writeback = r_rights[s][2];
                    if (r_req.address == r_start[s] && stop == {1'b0, r_end[s]}) begin
                        r_used[s] <= 1'b0;
                        if (!nn[PTR_W-1]) r_prev[nn[IDX_W-1:0]] <= pv;
                        else r_tail <= pv;
                        if (!pv[PTR_W-1]) r_next[pv[IDX_W-1:0]] <= nn;
                        else r_head <= nn;
                        rsp.removed_whole = 1'b1;
                    end else if (r_req.address == r_start[s]) begin
                        r_start[s] <= r_start[s] + len;
                        r_offset[s] <= r_offset[s] + len;
                    end else begin
                        r_end[s] <= r_end[s] - len;
                    end
                end
            end
            r_rsp <= rsp;
        end
    end
endmodule

FILE: rtl/address_region_allocator.sv
// A request passes from the slot scan to a commit step and then to the result; a
// map that cannot be placed above the head also walks the region list, and a
// request rejected for permission or alignment skips the scan. One request at a
// time; the next word is taken only after the result is accepted, so the scan and walk set the rate.
// Reset (i_rst_n low, synchronous): all slots free, list empty,
// region_top back to its default.
module address_region_allocator
    import ara_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ara_req_if.sink           i_req,
    ara_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    ara_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    ara_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(i_req.data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_sts(sts), .o_rsp(o_rsp.data)
    );
endmodule

FILE: rtl/ara_checker.sv
module ara_checker
    import ara_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input t_rsp out_data
);
    // A new word is never taken while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.status <= ST_UNSUP) else $error("bad status");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind address_region_allocator ara_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_req.valid), .in_ready(i_req.ready),
    .out_valid(o_rsp.valid), .out_ready(o_rsp.ready), .out_data(o_rsp.data)
);

FILE: tb/ara_tb_if.sv
`timescale 1ns / 100ps
// The block's channel interfaces come with the RTL. This file holds the
// testbench's own item types, kept apart so that the top file stays focused.
package ara_tb_pkg;
    import ara_pkg::*;

    localparam logic OP_MAP = 1'b0;
    localparam logic OP_UNMAP = 1'b1;
    localparam logic [ADDR_W-1:0] PAGE = 38'd4096;

    typedef struct {
        t_req req;
        logic cfg;
        logic [ADDR_W-1:0] top;
    } t_pending;
endpackage

FILE: tb/address_region_allocator_tb.sv
`timescale 1ns / 100ps
module address_region_allocator_tb;
    import ara_pkg::*;
    import ara_tb_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam logic [ADDR_W-1:0] AMAX = {ADDR_W{1'b1}};

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_data = '0;

    ara_req_if req_ch ();
    ara_rsp_if rsp_ch ();

    address_region_allocator i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor state: a shadow of the region table.
    logic              m_used [ENTRIES];
    logic [ADDR_W-1:0] m_start [ENTRIES];
    logic [ADDR_W-1:0] m_end [ENTRIES];
    int                m_next [ENTRIES];
    int                m_prev [ENTRIES];
    logic [2:0]        m_rights [ENTRIES];
    logic [3:0]        m_file [ENTRIES];
    logic [ADDR_W-1:0] m_offset [ENTRIES];
    int                m_head;
    int                m_tail;
    logic [ADDR_W-1:0] m_top;

    t_pending pending_q[$];
    t_rsp     expected_rsp_q[$];

    int  mismatches = 0;
    int  n_sent = 0;
    int  n_recv = 0;
    int  n_ok = 0;
    int  n_err = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    bit  stim_done;

    function automatic logic [ADDR_W-1:0] pg(input logic [ADDR_W-1:0] v);
        return v & ~(PAGE - 1);
    endfunction

    function automatic t_rsp predict_map(input t_req r);
        t_rsp o;
        int i;
        int j;
        int nx;
        bit placed;
        logic [ADDR_W-1:0] top;
        logic [ADDR_W-1:0] fin;
        o = '0;
        if ((r.want_write && !r.file_can_write && r.is_shared) ||
            (r.want_read && !r.file_can_read)) begin
            o.status = ST_PERM;
            return o;
        end
        i = 0;
        while (i < ENTRIES && m_used[i]) i++;
        if (i >= ENTRIES) begin
            o.status = ST_FULL;
            return o;
        end
        top = pg(m_top);
        if (m_head < 0) begin
            m_next[i] = -1;
            m_prev[i] = -1;
            m_head = i;
            m_tail = i;
            fin = top;
        end else if (m_end[m_head] <= pg(top - r.length)) begin
            m_next[i] = m_head;
            m_prev[i] = -1;
            m_prev[m_head] = i;
            m_head = i;
            fin = top;
        end else begin
            placed = 0;
            j = m_head;
            fin = '0;
            for (int n = 0; n < ENTRIES && j >= 0 && !placed; n++) begin
                nx = m_next[j];
                if (nx >= 0 && m_end[nx] <= pg(m_start[j] - r.length)) begin
                    m_prev[i] = j;
                    m_next[i] = nx;
                    m_next[j] = i;
                    m_prev[nx] = i;
                    fin = m_start[j];
                    placed = 1;
                end
                j = nx;
            end
            if (!placed) begin
                m_next[i] = -1;
                m_prev[i] = m_tail;
                fin = m_start[m_tail];
                m_next[m_tail] = i;
                m_tail = i;
            end
        end
        m_used[i] = 1;
        m_end[i] = fin;
        m_start[i] = pg(fin - r.length);
        m_rights[i] = {r.is_shared, r.want_write, r.want_read};
        m_file[i] = r.file_number;
        m_offset[i] = r.start_offset;
        o.status = ST_OK;
        o.mapped_start = m_start[i];
        o.slot = i[3:0];
        return o;
    endfunction

    function automatic t_rsp predict_unmap(input t_req r);
        t_rsp o;
        logic [ADDR_W:0] stop;
        int i;
        o = '0;
        // The end of the range is formed one bit wider so that it cannot wrap.
        stop = {1'b0, r.address} + {1'b0, r.length};
        if (r.address[PAGE_BITS-1:0] != 0 || stop[PAGE_BITS-1:0] != 0) begin
            o.status = ST_UNSUP;
            return o;
        end
        i = 0;
        while (i < ENTRIES && !(m_used[i] && m_start[i] <= r.address &&
                                stop <= {1'b0, m_end[i]})) i++;
        if (i >= ENTRIES) begin
            o.status = ST_NOREGION;
            return o;
        end
        o.slot = i[3:0];
        o.region_file = m_file[i];
        o.region_offset = m_offset[i];
        if (r.address > m_start[i] && stop < {1'b0, m_end[i]}) begin
            o.status = ST_UNSUP;
            return o;
        end
        o.status = ST_OK;
        o.needs_writeback = m_rights[i][2];
        if (r.address == m_start[i] && stop == {1'b0, m_end[i]}) begin
            m_used[i] = 0;
            if (m_next[i] >= 0) m_prev[m_next[i]] = m_prev[i];
            else m_tail = m_prev[i];
            if (m_prev[i] >= 0) m_next[m_prev[i]] = m_next[i];
            else m_head = m_next[i];
            o.removed_whole = 1;
        end else if (r.address == m_start[i]) begin
            m_start[i] = m_start[i] + r.length;
            m_offset[i] = m_offset[i] + r.length;
        end else begin
            m_end[i] = m_end[i] - r.length;
        end
        return o;
    endfunction

    function automatic t_req make_map(input logic [ADDR_W-1:0] len);
        t_req r;
        r = '0;
        r.opcode = OP_MAP;
        r.address = ADDR_W'({$urandom, $urandom});
        r.length = len;
        r.want_read = 1'($urandom_range(0, 1));
        r.want_write = 1'($urandom_range(0, 1));
        r.is_shared = 1'($urandom_range(0, 1));
        r.file_number = 4'($urandom_range(0, 15));
        r.file_can_read = ($urandom_range(0, 9) != 0);
        r.file_can_write = ($urandom_range(0, 9) != 0);
        r.start_offset = ADDR_W'({$urandom, $urandom});
        return r;
    endfunction

    function automatic t_req make_unmap(input logic [ADDR_W-1:0] addr,
                                        input logic [ADDR_W-1:0] len);
        t_req r;
        r = make_map(len);
        r.opcode = OP_UNMAP;
        r.address = addr;
        return r;
    endfunction

    task automatic push_req(input t_req r);
        t_pending p;
        p.req = r;
        p.cfg = 0;
        p.top = '0;
        pending_q.push_back(p);
    endtask

    task automatic push_cfg(input logic [ADDR_W-1:0] v);
        t_pending p;
        p.req = '0;
        p.cfg = 1;
        p.top = v;
        pending_q.push_back(p);
    endtask

    // Mostly small page-multiple lengths; an occasional huge or ragged one.
    function automatic logic [ADDR_W-1:0] rand_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return PAGE * ADDR_W'($urandom_range(0, 8));
        if (sel < 85) return PAGE * ADDR_W'($urandom_range(0, 4096));
        if (sel < 93) return ADDR_W'({$urandom, $urandom});
        return ADDR_W'($urandom_range(0, 20000));
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        logic [ADDR_W-1:0] tops [5];
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] l;
        int sel;
        tops = '{TOP_RESET, AMAX, 38'd0, 38'd65536 + 38'd123, 38'h20_0000_0000};
        stim_done = 0;
        // Directed part at the reset top: both ops, extremes and special cases.
        push_req(make_map(PAGE));
        push_req(make_map(0));                    // empty region
        push_req(make_map(AMAX));                 // huge length wraps placement
        push_req(make_map(PAGE * 3));
        push_req(make_unmap(TOP_RESET - PAGE, PAGE));   // whole region
        push_req(make_unmap(38'd5, PAGE));        // unaligned
        push_req(make_unmap(AMAX & ~(PAGE - 1), PAGE)); // range past space
        push_req(make_unmap(AMAX, AMAX));
        push_req(make_unmap(38'd0, 38'd0));
        for (int k = 0; k < 14; k++)
            push_req(make_map(PAGE * ADDR_W'($urandom_range(1, 4))));
        push_cfg(AMAX);
        // Random part in five phases; every phase but the first writes a top from the tops table.
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) push_cfg(tops[ph]);
            for (int k = 0; k < 150; k++) begin
                sel = $urandom_range(0, 99);
                l = rand_len();
                if (sel < 45) begin
                    push_req(make_map(l));
                end else begin
                    // Unmaps are aimed near the current top so they find regions.
                    a = pg(tops[ph]) - PAGE * ADDR_W'($urandom_range(0, 64));
                    if (sel >= 95) a = ADDR_W'({$urandom, $urandom});
                    if (sel >= 90 && sel < 95) a = a + ADDR_W'($urandom_range(1, 4095));
                    if ($urandom_range(0, 3) == 0) l = PAGE * ADDR_W'($urandom_range(0, 3));
                    push_req(make_unmap(a, l));
                end
            end
        end
        stim_done = 1;
    end

    // Reset, configuration writes and request driving.
    int rst_cnt = 0;
    int quiet_cnt = 0;
    int settle = 0;
    always @(posedge i_clk) begin
        logic cfg_we;
        cfg_we = 1'b0;
        if (rst_cnt < 8) begin
            rst_cnt <= rst_cnt + 1;
            i_rst_n <= (rst_cnt == 7);
            req_ch.valid <= 0;
            m_top = TOP_RESET;
            m_head = -1;
            m_tail = -1;
            for (int k = 0; k < ENTRIES; k++) begin
                m_used[k] = 0;
                m_next[k] = -1;
                m_prev[k] = -1;
            end
        end else begin
            quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt == 300) quiet <= 1;
            if (quiet_cnt == 700) quiet <= 0;
            if (req_ch.valid && req_ch.ready) begin
                n_sent <= n_sent + 1;
                settle <= 0;
            end else if (!req_ch.valid) begin
                settle <= settle + 1;
            end
            if (req_ch.valid && !req_ch.ready) begin
                // hold the word
            end else if (pending_q.size() > 0 && pending_q[0].cfg) begin
                req_ch.valid <= 0;
                // Write only once every result is back and the block has settled.
                if (expected_rsp_q.size() == 0 && !(req_ch.valid && req_ch.ready) &&
                    settle > 2 * ENTRIES + 8) begin
                    cfg_we = 1'b1;
                    i_cfg_data <= pending_q[0].top;
                    m_top = pending_q[0].top;
                    void'(pending_q.pop_front());
                end
            end else if (pending_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
                req_ch.valid <= 1;
                req_ch.data <= pending_q[0].req;
                if (pending_q[0].req.opcode == OP_UNMAP)
                    expected_rsp_q.push_back(predict_unmap(pending_q[0].req));
                else
                    expected_rsp_q.push_back(predict_map(pending_q[0].req));
                void'(pending_q.pop_front());
            end else begin
                req_ch.valid <= 0;
            end
        end
        i_cfg_we <= cfg_we;
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            rsp_ch.ready <= 0;
        end else begin
            rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 7);
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_recv <= n_recv + 1;
                idle_cycles <= 0;
                if (expected_rsp_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected word: %p", rsp_ch.data);
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (exp_rsp.status == ST_OK) n_ok <= n_ok + 1;
                    else n_err <= n_err + 1;
                    if (rsp_ch.data !== exp_rsp) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p actual %p", exp_rsp, rsp_ch.data);
                    end
                end
            end else if (!(req_ch.valid && req_ch.ready)) begin
                idle_cycles <= idle_cycles + 1;
            end else begin
                idle_cycles <= 0;
            end
        end
    end

    initial begin
        wait (i_rst_n);
        while (!(stim_done && pending_q.size() == 0 && !req_ch.valid &&
                 expected_rsp_q.size() == 0) && idle_cycles < WATCHDOG)
            @(posedge i_clk);
        if (idle_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            repeat (2 * ENTRIES + 10) @(posedge i_clk);
            $display("Covered %0d requests, %0d results: %0d ok, %0d error statuses.",
                     n_sent, n_recv, n_ok, n_err);
            $display("Five region tops were used, the minimum and maximum among them.");
            if (mismatches == 0 && expected_rsp_q.size() == 0) begin
                $display("*** PASSED ***");
            end else begin
                $display("*** FAILED ***");
            end
            $finish;
        end
    end
endmodule
